### rtl/core/ccg_pkg.sv
package ccg_pkg;

  // Largest generator degree the datapath carries.
  localparam int MAX_DEGREE = 32;
  // Field widths fixed by the register map.
  localparam int TAPS_W     = 32;
  localparam int DEG_W      = 6;
  localparam int POS_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  // Decoupling queue between front and back.
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW        = $clog2(QDEPTH + 1);

  // Register map, index = byte address / 4.
  localparam int PADDR_W    = 3;
  localparam logic REG_TAPS   = 1'b0;
  localparam logic REG_DEGREE = 1'b1;

  localparam logic [TAPS_W-1:0] TAPS_RESET   = 32'h04C1_1DB7;
  localparam logic [DEG_W-1:0]  DEGREE_RESET = 6'd32;

  typedef enum logic {
    ST_MSG,
    ST_CHECK
  } ccg_state_e;

  typedef struct packed {
    logic [TAPS_W-1:0] taps;
    logic [DEG_W-1:0]  degree;
  } ccg_cfg_t;

  typedef struct packed {
    logic                  msg_bit;
    logic                  last;
    logic [MAX_DEGREE-1:0] rem;
  } ccg_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ccg_qstat_t;

  // Saturate the programmed degree into 1..MAX_DEGREE.
  function automatic logic [DEG_W-1:0] used_degree(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] d;
    d = deg;
    if (deg == '0) begin
      d = DEG_W'(1);
    end else if (int'(deg) > MAX_DEGREE) begin
      d = DEG_W'(MAX_DEGREE);
    end
    return d;
  endfunction

  // Ones in the low d bits.
  function automatic logic [MAX_DEGREE-1:0] degree_mask(input logic [DEG_W-1:0] d);
    logic [MAX_DEGREE:0] m;
    m = ((MAX_DEGREE+1)'(1) << d) - (MAX_DEGREE+1)'(1);
    return m[MAX_DEGREE-1:0];
  endfunction

  // Bit position of the remainder's top bit for degree d.
  function automatic logic [POS_W-1:0] top_pos(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] p;
    p = d - DEG_W'(1);
    return POS_W'(p);
  endfunction

endpackage

### rtl/core/ccg_front.sv
module ccg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccg_pkg::ccg_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                message_bit_i,
  input  logic                frame_last_i,
  input  ccg_pkg::ccg_qstat_t qstat_i,
  output logic                push_o,
  output ccg_pkg::ccg_entry_t entry_o
);
  import ccg_pkg::*;

  logic [MAX_DEGREE-1:0] remainder_q, remainder_d;
  logic [MAX_DEGREE-1:0] mask, taps, rem, rem_next;
  logic [DEG_W-1:0]      deg;
  logic                  fb;

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // One masked shift-and-XOR step of the running remainder.
  always_comb begin
    deg      = used_degree(cfg_i.degree);
    mask     = degree_mask(deg);
    taps     = MAX_DEGREE'(cfg_i.taps) & mask;
    rem      = remainder_q & mask;
    fb       = message_bit_i ^ rem[top_pos(deg)];
    rem_next = (rem << 1) & mask;
    if (fb) begin
      rem_next = rem_next ^ taps;
    end
    remainder_d = remainder_q;
    if (push_o) begin
      remainder_d = frame_last_i ? '0 : rem_next;
    end
  end

  assign entry_o.msg_bit = message_bit_i;
  assign entry_o.last    = frame_last_i;
  assign entry_o.rem     = rem_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remainder_q <= '0;
    end else begin
      remainder_q <= remainder_d;
    end
  end

endmodule

### rtl/core/ccg_queue.sv
module ccg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ccg_pkg::ccg_entry_t entry_i,
  input  logic                pop_i,
  output ccg_pkg::ccg_entry_t head_o,
  output ccg_pkg::ccg_qstat_t qstat_o
);
  import ccg_pkg::*;

  ccg_entry_t           slots_q [QDEPTH];
  logic [QAW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]       count_q, count_d;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == QCW'(QDEPTH));
  assign head_o        = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/ccg_back.sv
module ccg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccg_pkg::ccg_cfg_t   cfg_i,
  input  ccg_pkg::ccg_entry_t head_i,
  input  ccg_pkg::ccg_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                code_bit_o,
  output logic                is_check_bit_o,
  output logic                codeword_end_o
);
  import ccg_pkg::*;

  ccg_state_e            state_q, state_d;
  logic [MAX_DEGREE-1:0] shift_q, shift_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  out_valid_q, out_valid_d;
  logic                  code_bit_q, code_bit_d;
  logic                  is_check_q, is_check_d;
  logic                  end_q, end_d;
  logic                  have, load;

  always_comb begin
    have        = (state_q == ST_CHECK) || !qstat_i.empty;
    load        = have && (!out_valid_q || !out_stall_i);
    state_d     = state_q;
    shift_d     = shift_q;
    pos_d       = pos_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    code_bit_d  = code_bit_q;
    is_check_d  = is_check_q;
    end_d       = end_q;
    unique case (state_q)
      ST_MSG: begin
        if (load) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          code_bit_d  = head_i.msg_bit;
          is_check_d  = 1'b0;
          end_d       = 1'b0;
          if (head_i.last) begin
            state_d = ST_CHECK;
            shift_d = head_i.rem;
            pos_d   = top_pos(used_degree(cfg_i.degree));
          end
        end
      end
      ST_CHECK: begin
        if (load) begin
          out_valid_d = 1'b1;
          code_bit_d  = shift_q[pos_q];
          is_check_d  = 1'b1;
          end_d       = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = ST_MSG;
          end else begin
            pos_d = pos_q - POS_W'(1);
          end
        end
      end
      default: state_d = ST_MSG;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign code_bit_o     = code_bit_q;
  assign is_check_bit_o = is_check_q;
  assign codeword_end_o = end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MSG;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    code_bit_q <= code_bit_d;
    is_check_q <= is_check_d;
    end_q      <= end_d;
  end

endmodule

### rtl/core/crc_codeword_generator_unit.sv
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_stall_o      | message_bit_i, frame_last_i
// out     | output    | out_valid_o / out_stall_i    | code_bit_o,
//         |           |                              | is_check_bit_o, codeword_end_o
// cfg     | input     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One message bit is taken per cycle while the queue is not full; a frame's
// last bit is followed by degree (1..32) check bits from the back-end serializer.
// A taken bit is written into the queue, then loaded into the output
// register, which presents the result.
// Reset clears the remainder, the queue and the output valid flag; the
// generator resets to 0x04C11DB7 with degree 32.
// Input stalls only when the two-entry queue is full; output stalls hold
// the output register and backpressure the queue.
module crc_codeword_generator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        message_bit_i,
  input  logic                        frame_last_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        code_bit_o,
  output logic                        is_check_bit_o,
  output logic                        codeword_end_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ccg_pkg::*;

  logic [TAPS_W-1:0] taps_q;
  logic [DEG_W-1:0]  degree_q;
  logic              cfg_write;
  logic              reg_sel;
  ccg_cfg_t          cfg;
  ccg_entry_t        push_entry, head_entry;
  ccg_qstat_t        qstat;
  logic              push, pop;

  // Registers: taps at 0x0, degree at 0x4. Writes land in the access phase.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_TAPS:   prdata = taps_q;
      REG_DEGREE: prdata = 32'(degree_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q   <= TAPS_RESET;
      degree_q <= DEGREE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_TAPS) begin
        taps_q <= pwdata;
      end else begin
        degree_q <= pwdata[DEG_W-1:0];
      end
    end
  end

  assign cfg.taps   = taps_q;
  assign cfg.degree = degree_q;

  // Front: advance the remainder per accepted bit, snapshot it into the queue.
  ccg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .message_bit_i (message_bit_i),
    .frame_last_i  (frame_last_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  ccg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .qstat_o (qstat)
  );

  // Back: pass the message bit, then shift out the check bits MSB first.
  ccg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .head_i         (head_entry),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_bit_o     (code_bit_o),
    .is_check_bit_o (is_check_bit_o),
    .codeword_end_o (codeword_end_o)
  );

`ifndef SYNTHESIS
  a_end_is_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && codeword_end_o |-> is_check_bit_o)
    else $error("codeword end flagged on a message bit");

  a_check_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_check_bit_o && !codeword_end_o
    |=> out_valid_o && is_check_bit_o)
    else $error("check-bit run broken before its end");

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty) && !(pop && qstat.empty))
    else $error("queue status inconsistent");
`endif

endmodule

### bench/crc_codeword_checker.sv
// Watches both channels and the register port, predicts every codeword bit
// and compares it with what the unit sends out.
module crc_codeword_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic                        message_bit_i,
  input  logic                        frame_last_i,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic                        code_bit_o,
  input  logic                        is_check_bit_o,
  input  logic                        codeword_end_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ccg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          error_cnt,
  output int                          pending_cnt
);

  localparam int MaxDeg = ccg_pkg::MAX_DEGREE;

  typedef struct packed {
    logic code_bit;
    logic is_check;
    logic final_check;
  } code_bit_t;

  logic [ccg_pkg::TAPS_W-1:0] gen_taps;
  logic [ccg_pkg::DEG_W-1:0]  gen_degree;
  logic [MaxDeg-1:0]          crc_rem;
  code_bit_t                  codeword_q[$];
  code_bit_t                  got_bit;
  code_bit_t                  want_bit;

  // Degree 0 acts as 1, anything above the datapath width as the width.
  function automatic int clamp_degree(input logic [ccg_pkg::DEG_W-1:0] deg);
    if (deg == '0) return 1;
    if (int'(deg) > MaxDeg) return MaxDeg;
    return int'(deg);
  endfunction

  // Advance the remainder by one message bit and queue the bits it yields.
  task automatic shift_in_bit(input logic msg_bit, input logic last);
    int                deg;
    logic [63:0]       wide_mask;
    logic [MaxDeg-1:0] mask;
    logic [MaxDeg-1:0] rem;
    logic              feedback;
    deg       = clamp_degree(gen_degree);
    wide_mask = (64'd1 << deg) - 64'd1;
    mask      = wide_mask[MaxDeg-1:0];
    rem       = crc_rem & mask;
    feedback  = msg_bit ^ rem[deg-1];
    rem       = (rem << 1) & mask;
    if (feedback) rem ^= MaxDeg'(gen_taps) & mask;
    crc_rem = rem;
    codeword_q.push_back('{msg_bit, 1'b0, 1'b0});
    if (last) begin
      for (int i = deg - 1; i >= 0; i--) begin
        codeword_q.push_back('{rem[i], 1'b1, (i == 0)});
      end
      crc_rem = '0;
    end
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
      error_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_taps    = ccg_pkg::TAPS_RESET;
      gen_degree  = ccg_pkg::DEGREE_RESET;
      crc_rem     = '0;
      codeword_q.delete();
      error_cnt   = 0;
      pending_cnt = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_bit = '{code_bit_o, is_check_bit_o, codeword_end_o};
        if (codeword_q.size() == 0) begin
          $display("%0t: unexpected output, expected none actual %b", $time, got_bit);
          error_cnt++;
        end else begin
          want_bit = codeword_q.pop_front();
          check_field("code_bit", want_bit.code_bit, got_bit.code_bit);
          check_field("is_check_bit", want_bit.is_check, got_bit.is_check);
          check_field("codeword_end", want_bit.final_check, got_bit.final_check);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        shift_in_bit(message_bit_i, frame_last_i);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[ccg_pkg::PADDR_W-1:2] == ccg_pkg::REG_TAPS) begin
          gen_taps = pwdata[ccg_pkg::TAPS_W-1:0];
        end else if (paddr[ccg_pkg::PADDR_W-1:2] == ccg_pkg::REG_DEGREE) begin
          gen_degree = pwdata[ccg_pkg::DEG_W-1:0];
        end
      end
      pending_cnt = codeword_q.size();
    end
  end

endmodule

### bench/tb_crc_codeword_generator_unit.sv
// Stimulus and verdict for the CRC codeword generator. Output checking lives in
// the checker instance; this module drives the ports and watches for a hang.
module tb_crc_codeword_generator_unit;

  // Stop once this many message bits have gone in (directed plus random).
  localparam int ItemTarget = 130;
  // Cycles without any transaction before the run is declared hung.
  localparam int IdleLimit  = 2000;
  // Hold-off after the last result, to catch stray extra outputs.
  localparam int TailCycles = 20;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_HOLD,
    RX_JITTER
  } rx_mode_e;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic                        message_bit_i = 1'b0;
  logic                        frame_last_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic                        code_bit_o;
  logic                        is_check_bit_o;
  logic                        codeword_end_o;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [ccg_pkg::PADDR_W-1:0] paddr         = '0;
  logic [31:0]                 pwdata        = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  int       error_cnt;
  int       pending_cnt;
  int       items_sent  = 0;
  int       burst_left  = 0;
  bit       steady      = 1'b0;
  int       idle_cycles = 0;
  int       rx_left     = 0;
  rx_mode_e rx_mode     = RX_FREE;

  crc_codeword_generator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_bit_i  (message_bit_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_bit_o     (code_bit_o),
    .is_check_bit_o (is_check_bit_o),
    .codeword_end_o (codeword_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  crc_codeword_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_bit_i  (message_bit_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_bit_o     (code_bit_o),
    .is_check_bit_o (is_check_bit_o),
    .codeword_end_o (codeword_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .error_cnt      (error_cnt),
    .pending_cnt    (pending_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: alternate free-running stretches, solid stalls and cycle-by-cycle
  // jitter so that backpressure lands on message bits and check bits alike.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 8) : $urandom_range(4, 24);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: begin
        out_stall_i = 1'b0;
      end
      RX_HOLD: begin
        out_stall_i = 1'b1;
      end
      default: begin
        out_stall_i = 1'($urandom_range(0, 1));
      end
    endcase
  end

  // Watchdog: any transaction on either channel or the register port clears it.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write one register: setup cycle, then access until pready is seen.
  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ccg_pkg::PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Offer one message bit; open a new burst after a random gap when the
  // current one runs out, unless a steady stretch is in force.
  task automatic send_bit(input logic msg_bit, input logic last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i    = 1'b0;
        message_bit_i = 1'($urandom_range(0, 1));
        frame_last_i  = 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    message_bit_i = msg_bit;
    frame_last_i  = last;
    // Hold the transaction until the unit takes it.
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    items_sent++;
  endtask

  // Send the low len bits of msg, most significant first; close the frame
  // on the final bit only when asked, so a frame can span a register change.
  task automatic send_frame(input logic [63:0] msg, input int len, input bit closes);
    for (int k = len - 1; k >= 0; k--) begin
      send_bit(msg[k], closes && (k == 0));
    end
  endtask

  // Drop valid and hold off until every predicted bit has come out.
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  initial begin
    int               n_frames;
    int               len;
    bit               closes;
    logic [31:0]      taps_val;
    logic [5:0]       deg_val;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Default generator: single-bit frames of both values, then a short one.
    send_frame(64'h1, 1, 1'b1);
    send_frame(64'h0, 1, 1'b1);
    send_frame(64'hB, 4, 1'b1);

    // Taps above the degree must be dropped.
    wait_results();
    reg_write(ccg_pkg::REG_TAPS, 32'hFFFF_FFFF);
    reg_write(ccg_pkg::REG_DEGREE, 32'd3);
    send_frame(64'hD, 4, 1'b1);

    // Degree zero acts as degree one; upper write bits are not part of it.
    wait_results();
    reg_write(ccg_pkg::REG_DEGREE, 32'hFFFF_FFC0);
    reg_write(ccg_pkg::REG_TAPS, 32'h0000_0001);
    send_frame(64'h2, 2, 1'b1);

    // Degree above the width saturates.
    wait_results();
    reg_write(ccg_pkg::REG_DEGREE, 32'd63);
    reg_write(ccg_pkg::REG_TAPS, 32'h8005_1021);
    send_frame(64'h3, 2, 1'b1);

    // Change the degree in the middle of a frame.
    wait_results();
    reg_write(ccg_pkg::REG_DEGREE, 32'd33);
    send_frame(64'h5, 3, 1'b0);
    wait_results();
    reg_write(ccg_pkg::REG_DEGREE, 32'd8);
    reg_write(ccg_pkg::REG_TAPS, 32'h0000_0007);
    send_frame(64'h2, 2, 1'b1);

    // Zero taps at full degree.
    wait_results();
    reg_write(ccg_pkg::REG_DEGREE, 32'd32);
    reg_write(ccg_pkg::REG_TAPS, 32'h0);
    send_frame(64'h1, 3, 1'b1);

    // Random phases: reprogram while idle, then a few frames each.
    while (items_sent < ItemTarget) begin
      wait_results();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: taps_val = '0;
          1: taps_val = '1;
          default: taps_val = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0: deg_val = 6'd0;
          1: deg_val = 6'd1;
          2: deg_val = 6'd32;
          3: deg_val = 6'($urandom_range(33, 63));
          default: deg_val = 6'($urandom_range(1, 32));
        endcase
        if ($urandom_range(0, 4) != 0) reg_write(ccg_pkg::REG_TAPS, taps_val);
        if ($urandom_range(0, 4) != 0) begin
          reg_write(ccg_pkg::REG_DEGREE, {26'($urandom), deg_val});
        end
      end
      steady   = ($urandom_range(0, 3) == 0);
      n_frames = $urandom_range(1, 4);
      for (int f = 0; f < n_frames; f++) begin
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        closes = (f != n_frames - 1) || ($urandom_range(0, 3) != 0);
        send_frame({$urandom, $urandom}, len, closes);
      end
    end

    // Drain, then hold a little longer for anything extra coming out.
    wait_results();
    repeat (TailCycles) @(negedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
